// ----- hdl/isort_pkg.sv -----
`timescale 1ns / 1ps
// Package for the insertion sorter: payload structs, controller states,
// and the command/status bundles between controller and datapath.
// No dependencies.
package isort_pkg;

  localparam int DataWidth = 32;
  localparam int Capacity  = 64;

  // Input transaction payload
  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last_in;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        last_out;
    logic                        overflow;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_INS_CMP,
    ST_DRAIN_READ,
    ST_DRAIN_LOAD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;   // capture the accepted input item
    logic rd_pos;      // read the entry just below the insert position
    logic shift;       // move the read entry up one slot
    logic place;       // write the key at the insert position
    logic drop;        // store full: flag the loss
    logic drain_rd;    // read the entry at the drain index
    logic drain_load;  // load the read entry into the output register
    logic clear;       // end of set: empty the store
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic pos_zero;
    logic ahead;       // key goes ahead of the entry just read
    logic last_item;
    logic drain_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/insertion_sorter.sv -----
`timescale 1ns / 1ps
// Insertion sorter top level. An accepted item works down the store one step at a
// time (one store read plus one compare per step) until it reaches the bottom of
// the store or a compare stops it; an item offered to a full store is dropped.
// After the item marked last, the set drains one result at a time (store read,
// output load), held by any output stall. Synchronous reset empties the set and the
// output register and clears the order bit; store contents are not cleared.
module insertion_sorter
  import isort_pkg::*;
#(
  parameter int CAPACITY = Capacity
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  isort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  isort_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- hdl/isort_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/isort_datapath.sv -----
`timescale 1ns / 1ps
// Sorter datapath: key and position registers, fill count, drop flag,
// order register, store RAM and output register. Uses isort_pkg, isort_ram.
module isort_datapath
  import isort_pkg::*;
#(
  parameter int CAPACITY = Capacity
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [DataWidth-1:0] key;
  logic                        key_last;
  logic [AW-1:0]               pos;
  logic [AW-1:0]               idx;
  logic [CW-1:0]               fill;
  logic                        dropped;
  logic                        descending;

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [DataWidth-1:0] ram_wr_data;
  logic [DataWidth-1:0] ram_rd_data;
  logic signed [DataWidth-1:0] held;
  logic                 out_free;

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_wr_en) begin
      descending <= cfg_wr_data;
    end
  end

  // Item key and insert position
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key      <= in_data.value;
      key_last <= in_data.last_in;
      pos      <= fill[AW-1:0];
    end else if (cmd.shift) begin
      pos <= pos - AW'(1);
    end
  end

  // Fill count, drop flag and drain index
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill    <= '0;
      dropped <= 1'b0;
      idx     <= '0;
    end else begin
      if (cmd.place) begin
        fill <= fill + CW'(1);
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
      if (cmd.drain_load) begin
        idx <= idx + AW'(1);
      end
    end
  end

  // Store access: shifts and placement write at pos, reads below pos or at idx
  assign ram_wr_en   = cmd.shift | cmd.place;
  assign ram_wr_data = cmd.shift ? ram_rd_data : key;
  assign ram_rd_addr = cmd.drain_rd ? idx : pos - AW'(1);

  isort_ram #(
    .WIDTH (DataWidth),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pos),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_pos | cmd.drain_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign held = $signed(ram_rd_data);

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.drain_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      out_data.sorted_value <= held;
      out_data.last_out     <= sts.drain_done;
      out_data.overflow     <= dropped;
    end
  end

  assign out_free = !out_valid || !out_stall;

  // Status to controller
  always_comb begin
    sts.full       = (fill == CW'(CAPACITY));
    sts.pos_zero   = (pos == '0);
    sts.ahead      = descending ? (key > held) : (key < held);
    sts.last_item  = key_last;
    sts.drain_done = ((CW'(idx) + CW'(1)) == fill);
    sts.out_free   = out_free;
  end

endmodule

// ----- hdl/isort_ctrl.sv -----
`timescale 1ns / 1ps
// Sorter controller: sequences accept, insertion shifts and the drain.
// Uses isort_pkg.
module isort_ctrl
  import isort_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_INSERT;
      end
      ST_INSERT: begin
        if (sts.full || sts.pos_zero) begin
          state_next = sts.last_item ? ST_DRAIN_READ : ST_IDLE;
        end else begin
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sts.ahead) begin
          state_next = ST_INSERT;
        end else begin
          state_next = sts.last_item ? ST_DRAIN_READ : ST_IDLE;
        end
      end
      ST_DRAIN_READ: begin
        state_next = ST_DRAIN_LOAD;
      end
      ST_DRAIN_LOAD: begin
        if (sts.out_free) begin
          state_next = sts.drain_done ? ST_IDLE : ST_DRAIN_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_INSERT: begin
        if (sts.full) begin
          cmd.drop = 1'b1;
        end else if (sts.pos_zero) begin
          cmd.place = 1'b1;
        end else begin
          cmd.rd_pos = 1'b1;
        end
      end
      ST_INS_CMP: begin
        if (sts.ahead) begin
          cmd.shift = 1'b1;
        end else begin
          cmd.place = 1'b1;
        end
      end
      ST_DRAIN_READ: begin
        cmd.drain_rd = 1'b1;
      end
      ST_DRAIN_LOAD: begin
        if (sts.out_free) begin
          cmd.drain_load = 1'b1;
          cmd.clear      = sts.drain_done;
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- hdl/isort_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the insertion sorter, bound to the top level.
// Uses isort_pkg.
module isort_checker
  import isort_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // Come out of reset with no output pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Refuse input while a set is still draining
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_out |-> in_stall)
    else $error("input accepted during drain");

  // Keep the overflow flag steady across one set
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last_out |=>
      !out_valid || (out_data.overflow == $past(out_data.overflow)))
    else $error("overflow flag changed within a set");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/insertion_sorter_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for insertion_sorter: sends sets of signed values,
// predicts the sorted drain of each set and compares every output transaction.
// Depends on isort_pkg and the insertion_sorter RTL.
module insertion_sorter_test;
  import isort_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 2 * Capacity + 40;
  localparam int HOLD_CYCLES    = 600;
  localparam logic signed [DataWidth-1:0] MAX_VAL = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MIN_VAL = {1'b1, {(DataWidth-1){1'b0}}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  // Predicted sorter state
  logic                        order_desc = 1'b0;
  logic signed [DataWidth-1:0] held_values[Capacity];
  int                          held_count = 0;
  logic                        lost_flag = 1'b0;
  out_item_t                   pending_sorted[$];

  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  insertion_sorter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Drive output stall: long hold-off on request, otherwise random
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d", $signed(out_data.sorted_value));
        error_count++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_data.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 $signed(want.sorted_value), $signed(out_data.sorted_value));
          error_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_data.last_out);
          error_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one value, wait for the transaction, then update the prediction
  task automatic send_value(input logic signed [DataWidth-1:0] value, input logic last);
    in_item_t                    item;
    logic signed [DataWidth-1:0] key;
    int                          pos;
    out_item_t                   res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    item.value   = value;
    item.last_in = last;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    // Insert stably: shift only entries that the new key goes ahead of
    key = value;
    if (held_count >= Capacity) begin
      lost_flag = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && (order_desc ? key > held_values[pos-1] : key < held_values[pos-1])) begin
        held_values[pos] = held_values[pos-1];
        pos--;
      end
      held_values[pos] = key;
      held_count++;
    end
    // Flush the whole set on the last transaction
    if (last) begin
      for (int k = 0; k < held_count; k++) begin
        res.sorted_value = held_values[k];
        res.last_out     = (k == held_count - 1);
        res.overflow     = lost_flag;
        pending_sorted.push_back(res);
      end
      held_count = 0;
      lost_flag  = 1'b0;
    end
  endtask

  function automatic logic signed [DataWidth-1:0] pick_value();
    case ($urandom_range(7))
      0, 1: return DataWidth'(int'($urandom_range(4)) - 2);
      2:    return $urandom_range(1) ? MAX_VAL : MIN_VAL;
      default: return DataWidth'($urandom());
    endcase
  endfunction

  task automatic send_set(input int count);
    for (int k = 0; k < count; k++) send_value(pick_value(), k == count - 1);
  endtask

  // Drop valid, wait for all results, then let the block go idle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input logic desc);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    order_desc = desc;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  task automatic test_ascending_extremes();
    write_order(1'b0);
    send_value(0, 1'b0);
    send_value(MAX_VAL, 1'b0);
    send_value(MIN_VAL, 1'b0);
    send_value(-1, 1'b0);
    send_value(1, 1'b0);
    send_value(7, 1'b0);
    send_value(7, 1'b0);
    send_value(-7, 1'b0);
    send_value(MIN_VAL, 1'b0);
    send_value(MAX_VAL, 1'b1);
    // single-entry set
    send_value(42, 1'b1);
    drain_and_settle();
  endtask

  task automatic test_descending_extremes();
    write_order(1'b1);
    send_value(MIN_VAL, 1'b0);
    send_value(3, 1'b0);
    send_value(MAX_VAL, 1'b0);
    send_value(-3, 1'b0);
    send_value(3, 1'b0);
    send_value(0, 1'b1);
    send_value(MIN_VAL, 1'b1);
    drain_and_settle();
  endtask

  // Flip the order in mid-set: stored entries keep their places
  task automatic test_order_change();
    write_order(1'b0);
    send_value(5, 1'b0);
    send_value(-5, 1'b0);
    send_value(9, 1'b0);
    drain_and_settle();
    write_order(1'b1);
    send_value(1, 1'b0);
    send_value(20, 1'b0);
    send_value(-20, 1'b1);
    drain_and_settle();
  endtask

  // Fill the store past capacity; the dropped value carries the last mark
  task automatic test_overflow();
    write_order(1'($urandom_range(1)));
    send_set(Capacity + 2);
    drain_and_settle();
  endtask

  task automatic test_random_sets(input int tx_pct, input int rx_pct);
    int start;
    start = items_sent;
    set_idling(tx_pct, rx_pct);
    while (items_sent - start < 6) begin
      if ($urandom_range(2) == 0) begin
        drain_and_settle();
        write_order(1'($urandom_range(1)));
      end
      send_set($urandom_range(1, 10));
    end
    drain_and_settle();
  endtask

  // Stall the output for a long stretch while sets keep coming
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_seq <= hold_seq + 1;
    send_set(8);
    send_set(3);
    drain_and_settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    set_idling(0, 0);
    test_ascending_extremes();
    test_descending_extremes();
    test_order_change();
    set_idling(81, 0);
    test_overflow();
    test_random_sets(0, 0);
    test_random_sets(81, 0);
    test_random_sets(0, 81);
    test_random_sets(10, 10);
    test_backpressure();

    if (error_count == 0 && pending_sorted.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
